[rtl/touch_report_frame_parser_macros.svh]
// ----------------------------------------------------------------------------
// Touch report frame parser: assertion macros
// Shared concurrent-assertion wrappers for the checker.
// ----------------------------------------------------------------------------
`ifndef TOUCH_REPORT_FRAME_PARSER_MACROS_SVH
`define TOUCH_REPORT_FRAME_PARSER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define TRFP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("trfp assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define TRFP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("trfp assertion failed");

`endif

[rtl/trfp_pkg.sv]
// ----------------------------------------------------------------------------
// Touch report frame parser package
// Shared types and constants for the front, command queue and back parts.
// ----------------------------------------------------------------------------
package trfp_pkg;

  localparam logic [7:0] CTRL_FIRST   = 8'd3;
  localparam logic [7:0] CTRL_LAST    = 8'd0;
  localparam int unsigned POINT_BYTES  = 8;
  localparam int unsigned HEADER_BYTES = 4;
  localparam int unsigned MAX_POINTS   = 31;

  localparam logic [1:0] EMU_OFF  = 2'd0;
  localparam logic [1:0] EMU_LEFT = 2'd1;

  typedef enum logic [1:0] {
    KIND_CONTACT = 2'd0,
    KIND_SYNC    = 2'd1,
    KIND_TOUCH   = 2'd2
  } kind_e;

  // One request from the front: a contact, an end of frame, or both.
  typedef struct packed {
    logic        contact;
    logic        finish;
    logic        press;
    logic [15:0] id;
    logic [15:0] x;
    logic [15:0] y;
    logic [4:0]  count;
  } cmd_t;

  // One result item as shown on the output ports.
  typedef struct packed {
    kind_e       kind;
    logic [15:0] id;
    logic [15:0] x;
    logic [15:0] y;
    logic        pressed;
    logic        button;
    logic [4:0]  count;
    logic        last;
  } res_t;

endpackage

[rtl/touch_report_frame_parser.sv]
// ----------------------------------------------------------------------------
// Touch report frame parser
// Parses a multitouch response byte stream into contact, end-of-set and
// single-touch result items.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: drive data_byte_i and raise push; a byte is taken at a clock
//   edge with push high and full low. One byte can be taken every cycle while full is low.
//   Result queue: while empty is low the oldest result sits on the result
//   ports; pop it with pop. One result leaves per cycle at most.
//   Configuration: cfg_wdata_i is the emulation mode, written at an edge with
//   cfg_valid_i and cfg_ready_o high (ready is always high). Write it only
//   while no result is pending. It resets to 1 (left button).
//   Result path: a byte that closes a point or a frame is written to the request
//   queue, and its first result is then loaded into the output register; a byte
//   that causes three results delivers them one after another.
//   Throughput: one byte per cycle, held back only when the request queue
//   between the parser and the result expander fills, which happens when the
//   receiver stalls or pops slower than results are produced.
//   Reset: clears the parser to expect a header byte and empties both queues.
// ----------------------------------------------------------------------------
module touch_report_frame_parser
  import trfp_pkg::*;
#(
  parameter int unsigned CmdDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte input queue
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte_i,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_wdata_i,
  // result queue
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  kind_o,
  output logic [15:0] tracking_id_o,
  output logic [15:0] pos_x_o,
  output logic [15:0] pos_y_o,
  output logic        pressed_o,
  output logic        button_code_o,
  output logic [4:0]  contact_count_o,
  output logic        last_o
);

  logic [1:0] emu_q;
  logic       byte_take;
  logic       cmd_wr, cmd_rd, cmd_full, cmd_empty;
  cmd_t       cmd_wdata, cmd_rdata;
  logic       res_valid;
  res_t       res;

  // Emulation mode register; the channel never stalls.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emu_q <= EMU_LEFT;
    end else if (cfg_valid_i && cfg_ready_o) begin
      emu_q <= cfg_wdata_i;
    end
  end

  // Hold off new bytes whenever the request queue has no room: every byte
  // issues at most one request, so this is the only stall on the input side.
  assign full      = cmd_full;
  assign byte_take = push && !cmd_full;

  trfp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (byte_take),
    .byte_i       (data_byte_i),
    .cmd_valid_o  (cmd_wr),
    .cmd_o        (cmd_wdata)
  );

  trfp_cmd_fifo #(
    .Depth (CmdDepth)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (cmd_wr),
    .wdata_i (cmd_wdata),
    .full_o  (cmd_full),
    .rd_i    (cmd_rd),
    .rdata_o (cmd_rdata),
    .empty_o (cmd_empty)
  );

  // Expand each request into its results; advance the queue on the last one.
  trfp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .emu_i       (emu_q),
    .cmd_valid_i (!cmd_empty),
    .cmd_i       (cmd_rdata),
    .cmd_pop_o   (cmd_rd),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_pop_i   (pop)
  );

  // Drive the result queue ports from the output register.
  assign empty           = !res_valid;
  assign kind_o          = res.kind;
  assign tracking_id_o   = res.id;
  assign pos_x_o         = res.x;
  assign pos_y_o         = res.y;
  assign pressed_o       = res.pressed;
  assign button_code_o   = res.button;
  assign contact_count_o = res.count;
  assign last_o          = res.last;

endmodule

[rtl/trfp_cmd_fifo.sv]
// ----------------------------------------------------------------------------
// Command queue
// Small register queue that decouples the byte parser from result expansion.
// ----------------------------------------------------------------------------
module trfp_cmd_fifo
  import trfp_pkg::*;
#(
  parameter int unsigned Depth = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_i,
  input  cmd_t wdata_i,
  output logic full_o,
  input  logic rd_i,
  output cmd_t rdata_o,
  output logic empty_o
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  cmd_t             mem_q [Depth];
  logic [AddrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AddrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_wr, do_rd;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == AddrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == AddrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

[rtl/trfp_front.sv]
// ----------------------------------------------------------------------------
// Byte parser
// Checks frame headers, assembles point records and issues one request per
// byte that causes results.
// ----------------------------------------------------------------------------
module trfp_front
  import trfp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       byte_valid_i,
  input  logic [7:0] byte_i,
  output logic       cmd_valid_o,
  output cmd_t       cmd_o
);

  logic [1:0]  header_index_q, header_index_d;
  logic        in_payload_q, in_payload_d;
  logic [4:0]  point_index_q, point_index_d;
  logic [2:0]  byte_in_point_q, byte_in_point_d;
  logic [7:0]  first_control_q, first_control_d;
  logic [7:0]  point_total_q, point_total_d;
  logic [7:0]  frame_length_q, frame_length_d;
  logic [47:0] point_fields_q, point_fields_d;
  logic [7:0]  point_status_q, point_status_d;
  logic [10:0] want_len;
  logic [4:0]  index_next;
  logic        header_ok;

  always_comb begin
    header_index_d  = header_index_q;
    in_payload_d    = in_payload_q;
    point_index_d   = point_index_q;
    byte_in_point_d = byte_in_point_q;
    first_control_d = first_control_q;
    point_total_d   = point_total_q;
    frame_length_d  = frame_length_q;
    point_fields_d  = point_fields_q;
    point_status_d  = point_status_q;

    want_len   = 11'(point_total_q) * 11'(POINT_BYTES) + 11'(HEADER_BYTES);
    header_ok  = (first_control_q == CTRL_FIRST) && (byte_i == CTRL_LAST)
              && ({3'b000, frame_length_q} == want_len)
              && (point_total_q <= 8'(MAX_POINTS));
    index_next = point_index_q + 1'b1;

    cmd_valid_o   = 1'b0;
    cmd_o         = '0;
    cmd_o.count   = point_total_q[4:0];
    cmd_o.id      = point_fields_q[47:32];
    cmd_o.x       = point_fields_q[15:0];
    cmd_o.y       = point_fields_q[31:16];

    if (byte_valid_i) begin
      if (!in_payload_q) begin
        unique case (header_index_q)
          2'd0: begin
            first_control_d = byte_i;
            header_index_d  = 2'd1;
          end
          2'd1: begin
            point_total_d  = byte_i;
            header_index_d = 2'd2;
          end
          2'd2: begin
            frame_length_d = byte_i;
            header_index_d = 2'd3;
          end
          default: begin
            // Drop a bad header; the next byte opens a new one.
            header_index_d = 2'd0;
            if (header_ok) begin
              point_index_d   = '0;
              byte_in_point_d = '0;
              if (point_total_q == '0) begin
                cmd_valid_o  = 1'b1;
                cmd_o.finish = 1'b1;
              end else begin
                in_payload_d = 1'b1;
              end
            end
          end
        endcase
      end else begin
        if (byte_in_point_q < 3'd6) begin
          point_fields_d[{byte_in_point_q, 3'b000} +: 8] = byte_i;
        end else if (byte_in_point_q == 3'd6) begin
          point_status_d = byte_i;
        end
        if (byte_in_point_q == 3'd7) begin
          // Pad byte closes the point.
          byte_in_point_d = '0;
          cmd_valid_o     = 1'b1;
          cmd_o.contact   = 1'b1;
          point_index_d   = index_next;
          if ({3'b000, index_next} >= point_total_q) begin
            cmd_o.finish   = 1'b1;
            cmd_o.press    = (point_status_q != '0);
            in_payload_d   = 1'b0;
            header_index_d = 2'd0;
            point_index_d  = '0;
          end
        end else begin
          byte_in_point_d = byte_in_point_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_index_q  <= '0;
      in_payload_q    <= 1'b0;
      point_index_q   <= '0;
      byte_in_point_q <= '0;
    end else begin
      header_index_q  <= header_index_d;
      in_payload_q    <= in_payload_d;
      point_index_q   <= point_index_d;
      byte_in_point_q <= byte_in_point_d;
    end
  end

  always_ff @(posedge clk_i) begin
    first_control_q <= first_control_d;
    point_total_q   <= point_total_d;
    frame_length_q  <= frame_length_d;
    point_fields_q  <= point_fields_d;
    point_status_q  <= point_status_d;
  end

endmodule

[rtl/trfp_back.sv]
// ----------------------------------------------------------------------------
// Result expander
// Turns each queued request into one to three result items and holds the
// oldest one in an output register.
// ----------------------------------------------------------------------------
module trfp_back
  import trfp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [1:0] emu_i,
  input  logic       cmd_valid_i,
  input  cmd_t       cmd_i,
  output logic       cmd_pop_o,
  output logic       res_valid_o,
  output res_t       res_o,
  input  logic       res_pop_i
);

  typedef enum logic [1:0] {
    STEP_START,
    STEP_CONTACT,
    STEP_SYNC,
    STEP_TOUCH
  } step_e;

  step_e step_q, step_now, step_next;
  logic  out_valid_q;
  res_t  res_q, res_new;
  logic  touch_en, is_last, load;

  always_comb begin
    touch_en = (cmd_i.count <= 5'd1) && (emu_i != EMU_OFF);
    step_now = step_q;
    if (step_q == STEP_START) begin
      step_now = cmd_i.contact ? STEP_CONTACT : STEP_SYNC;
    end

    res_new       = '0;
    res_new.count = cmd_i.count;
    is_last       = 1'b1;
    step_next     = STEP_START;
    unique case (step_now)
      STEP_CONTACT: begin
        res_new.kind = KIND_CONTACT;
        res_new.id   = cmd_i.id;
        res_new.x    = cmd_i.x;
        res_new.y    = cmd_i.y;
        is_last      = !cmd_i.finish;
        step_next    = STEP_SYNC;
      end
      STEP_SYNC: begin
        res_new.kind = KIND_SYNC;
        is_last      = !touch_en;
        step_next    = STEP_TOUCH;
      end
      STEP_TOUCH: begin
        res_new.kind    = KIND_TOUCH;
        res_new.pressed = cmd_i.press;
        res_new.button  = (emu_i != EMU_LEFT);
        if (cmd_i.press) begin
          res_new.x = cmd_i.x;
          res_new.y = cmd_i.y;
        end
      end
      default: begin
        res_new.kind = KIND_SYNC;
      end
    endcase
    res_new.last = is_last;

    load      = cmd_valid_i && (!out_valid_q || res_pop_i);
    cmd_pop_o = load && is_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= STEP_START;
      out_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      out_valid_q <= load || (out_valid_q && !res_pop_i);
      if (load) begin
        res_q  <= res_new;
        step_q <= is_last ? STEP_START : step_next;
      end
    end
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

[rtl/trfp_checker.sv]
// ----------------------------------------------------------------------------
// Port checker
// Watches the result queue of the frame parser and is bound to its top level.
// ----------------------------------------------------------------------------
`include "touch_report_frame_parser_macros.svh"

module trfp_checker
  import trfp_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input logic [1:0]  kind_o,
  input logic [15:0] pos_x_o,
  input logic [15:0] pos_y_o,
  input logic        pressed_o,
  input logic        button_code_o,
  input logic        last_o
);

  logic shown_stalled;
  logic is_touch;

  assign shown_stalled = !empty && !pop;
  assign is_touch      = !empty && (kind_o == KIND_TOUCH);

  // A waiting result holds until it is popped.
  `TRFP_ASSERT_NEXT(a_hold_result, clk_i, rst_ni, shown_stalled, !empty && $stable(kind_o) && $stable(pos_x_o) && $stable(last_o))
  // A single-touch report always closes the results of its byte.
  `TRFP_ASSERT_IMPLY(a_touch_is_last, clk_i, rst_ni, is_touch, last_o)
  // Contacts and end-of-set results carry no button state.
  `TRFP_ASSERT_IMPLY(a_no_button, clk_i, rst_ni, !empty && !is_touch, !pressed_o && !button_code_o)
  // A release report carries no position.
  `TRFP_ASSERT_IMPLY(a_release_zero, clk_i, rst_ni, is_touch && !pressed_o, pos_x_o == '0 && pos_y_o == '0)

endmodule

bind touch_report_frame_parser trfp_checker u_trfp_checker (.*);
